@@ sv/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and the frequency to channel mapping of the
// radiotap / 802.11 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

    localparam int MAX_FRAME_BYTES = 65536;
    // byte counter holds 0 .. MAX_FRAME_BYTES
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    // offsets inside the radiotap header, with headroom for the alignment adds
    localparam int OFF_W = 18;
    localparam int HL_W  = 16;
    localparam int MAC_W = 48;

    localparam logic [OFF_W-1:0] MIN_HDR_LEN   = OFF_W'(8);
    localparam logic [OFF_W-1:0] MIN_FRAME_LEN = OFF_W'(8);
    localparam logic [OFF_W-1:0] MIN_MAC_LEN   = OFF_W'(10);
    localparam logic [OFF_W-1:0] CTRL_SRC_LEN  = OFF_W'(16);
    localparam logic [OFF_W-1:0] FULL_MAC_LEN  = OFF_W'(24);
    localparam logic [OFF_W-1:0] FIRST_PRESENT = OFF_W'(4);

    // radiotap byte positions
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PRESENT = POS_W'(4);

    // present bits of the first word
    localparam int PB_TSFT    = 0;
    localparam int PB_FLAGS   = 1;
    localparam int PB_RATE    = 2;
    localparam int PB_CHANNEL = 3;
    localparam int PB_FHSS    = 4;
    localparam int PB_SIGNAL  = 5;

    // frame control
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [3:0] SUB_PS_POLL  = 4'd10;
    localparam logic [3:0] SUB_RTS      = 4'd11;
    localparam int         RAND_BIT     = MAC_W - 7;

    // frequency plan (MHz)
    localparam logic [15:0] FREQ_CH14     = 16'd2484;
    localparam logic [7:0]  CHAN_14       = 8'd14;
    localparam logic [15:0] FREQ_24_LO    = 16'd2412;
    localparam logic [15:0] FREQ_24_HI    = 16'd2472;
    localparam logic [15:0] FREQ_5_LO     = 16'd5160;
    localparam logic [15:0] FREQ_5_HI     = 16'd5885;
    localparam logic [15:0] FREQ_5_BASE   = 16'd5000;
    localparam logic [15:0] FREQ_6_LO     = 16'd5955;
    localparam logic [15:0] FREQ_6_HI     = 16'd7115;
    localparam logic [15:0] FREQ_6_BASE   = 16'd5950;
    // floor(x/5) == (x * 3277) >> 14 for x below 16384
    localparam logic [24:0] DIV5_RECIP    = 25'd3277;
    localparam int          DIV5_SHIFT    = 14;

    typedef enum logic [1:0] {
        CHAIN_FIRST = 2'd0,
        CHAIN_EXT   = 2'd1,
        CHAIN_DONE  = 2'd2
    } t_chain;

    typedef struct packed {
        logic signed [7:0] signal_dbm;
        logic [7:0]        channel_number;
        logic [1:0]        frame_kind;
        logic [3:0]        frame_subkind;
        logic [MAC_W-1:0]  dest_address;
        logic [MAC_W-1:0]  source_address;
        logic [MAC_W-1:0]  bss_address;
        logic              randomized_source;
    } t_result;

    function automatic logic [7:0] chan_of_freq(input logic [15:0] f);
        logic [10:0] x;
        logic [24:0] p;
        logic [7:0]  q;
        logic [7:0]  ch;
        x  = '0;
        ch = '0;
        if (f >= FREQ_24_LO && f <= FREQ_24_HI) begin
            x = 11'(f - FREQ_24_LO);
        end else if (f >= FREQ_5_LO && f <= FREQ_5_HI) begin
            x = 11'(f - FREQ_5_BASE);
        end else if (f >= FREQ_6_LO && f <= FREQ_6_HI) begin
            x = 11'(f - FREQ_6_BASE);
        end
        p = {14'd0, x} * DIV5_RECIP;
        q = p[DIV5_SHIFT +: 8];
        if (f == FREQ_CH14) begin
            ch = CHAN_14;
        end else if (f >= FREQ_24_LO && f <= FREQ_24_HI) begin
            ch = q + 8'd1;
        end else if ((f >= FREQ_5_LO && f <= FREQ_5_HI) ||
                     (f >= FREQ_6_LO && f <= FREQ_6_HI)) begin
            ch = q;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ sv/radiotap_wifi_header_parser_unit.sv @@
// Results: a frame's last byte is held in the input register, then its result
//   is loaded into the result register when that last byte moves on.
// Throughput: one byte per cycle; a last byte waits in the input register only
//   while the previous result is still offered and not taken.
// Reset: synchronous active-low i_rst_n clears all frame state and both valids.
// ----------------------------------------------------------------------------
// radiotap_wifi_header_parser_unit
// Streams captured frame bytes, parses radiotap and 802.11 headers and gives
// one result per well-formed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module radiotap_wifi_header_parser_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic                      i_last_byte,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [7:0]              o_signal_dbm,
    output logic [7:0]                     o_channel_number,
    output logic [1:0]                     o_frame_kind,
    output logic [3:0]                     o_frame_subkind,
    output logic [rtp_pkg::MAC_W-1:0]      o_dest_address,
    output logic [rtp_pkg::MAC_W-1:0]      o_source_address,
    output logic [rtp_pkg::MAC_W-1:0]      o_bss_address,
    output logic                           o_randomized_source
);
    import rtp_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic        adv;
    logic        res_valid;
    t_result     res;
    logic [15:0] freq;
    logic [7:0]  chan;

    // a last byte moves on only when the result register is free
    assign adv         = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !adv);
    assign n_out_valid = (adv && res_valid) || (r_out_valid && !i_out_ready);

    rtp_chan u_chan (
        .i_clk  (i_clk),
        .i_freq (freq),
        .o_chan (chan)
    );

    rtp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_chan      (chan),
        .o_freq      (freq),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_signal_dbm        = r_out.signal_dbm;
    assign o_channel_number    = r_out.channel_number;
    assign o_frame_kind        = r_out.frame_kind;
    assign o_frame_subkind     = r_out.frame_subkind;
    assign o_dest_address      = r_out.dest_address;
    assign o_source_address    = r_out.source_address;
    assign o_bss_address       = r_out.bss_address;
    assign o_randomized_source = r_out.randomized_source;

endmodule

`default_nettype wire

@@ sv/rtp_chan.sv @@
// ----------------------------------------------------------------------------
// rtp_chan
// Registered frequency to channel number lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_chan (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_freq,
    output logic [7:0]       o_chan
);
    import rtp_pkg::*;

    logic [7:0] r_chan;
    logic [7:0] n_chan;

    always_comb begin
        n_chan = chan_of_freq(i_freq);
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire

@@ sv/rtp_parse.sv @@
// ----------------------------------------------------------------------------
// rtp_parse
// Per-byte radiotap / 802.11 header state and end-of-frame result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_parse (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [7:0]  i_chan,
    output logic [15:0]      o_freq,
    output logic             o_res_valid,
    output rtp_pkg::t_result o_res
);
    import rtp_pkg::*;

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [HL_W-1:0]  r_hl,    n_hl;
    logic [5:0]       r_fpb,   n_fpb;
    logic [OFF_W-1:0] r_pwo,   n_pwo;
    t_chain           r_chain, n_chain;
    logic             r_mal,   n_mal;
    logic [OFF_W-1:0] r_foff,  n_foff;
    logic [OFF_W-1:0] r_soff,  n_soff;
    logic [15:0]      r_freq,  n_freq;
    logic [7:0]       r_sig,   n_sig;
    logic [7:0]       r_fc,    n_fc;
    logic [MAC_W-1:0] r_a1,    n_a1;
    logic [MAC_W-1:0] r_a2,    n_a2;
    logic [MAC_W-1:0] r_a3,    n_a3;

    // values after this byte, before the end-of-frame clear
    logic [POS_W-1:0] u_pos;
    logic [HL_W-1:0]  u_hl;
    logic [5:0]       u_fpb;
    logic [OFF_W-1:0] u_pwo, u_foff, u_soff;
    t_chain           u_chain;
    logic             u_mal;
    logic [15:0]      u_freq;
    logic [7:0]       u_sig, u_fc;
    logic [MAC_W-1:0] u_a1, u_a2, u_a3;

    logic             take;
    logic [OFF_W-1:0] pos_x, hl_x, rel, off;
    logic             mal_pre, chain_hit, ext_bad;

    assign take    = r_pos < POS_W'(MAX_FRAME_BYTES);
    assign pos_x   = OFF_W'(r_pos);
    assign hl_x    = OFF_W'(r_hl);
    assign u_pos   = take ? r_pos + POS_W'(1) : r_pos;
    assign u_hl    = !take ? r_hl :
                     (r_pos == POS_LEN_LO) ? {8'd0, i_byte} :
                     (r_pos == POS_LEN_HI) ? {i_byte, r_hl[7:0]} : r_hl;
    assign mal_pre = r_mal | (take && r_pos == POS_LEN_HI && OFF_W'(u_hl) < MIN_HDR_LEN);
    assign chain_hit = take && !mal_pre && r_chain != CHAIN_DONE &&
                       r_pos >= POS_PRESENT && pos_x == r_pwo + OFF_W'(3);
    assign ext_bad = r_pwo + OFF_W'(8) > hl_x;
    assign rel     = pos_x - hl_x;

    // present-word chain
    always_comb begin
        u_chain = r_chain;
        if (chain_hit) begin
            if (!i_byte[7]) begin
                u_chain = CHAIN_DONE;
            end else if (!ext_bad) begin
                u_chain = CHAIN_EXT;
            end
        end
        n_chain = i_last ? CHAIN_FIRST : u_chain;
    end

    // field offsets, captures and result
    always_comb begin
        logic [OFF_W-1:0] n_len, rem;
        logic             ok;
        logic [1:0]       kind;
        logic [3:0]       sub;

        u_fpb  = r_fpb;
        u_pwo  = r_pwo;
        u_mal  = mal_pre;
        u_foff = r_foff;
        u_soff = r_soff;
        u_freq = r_freq;
        u_sig  = r_sig;
        u_fc   = r_fc;
        u_a1   = r_a1;
        u_a2   = r_a2;
        u_a3   = r_a3;
        off    = r_pwo + OFF_W'(4);

        if (take && !mal_pre) begin
            if (r_pos == POS_PRESENT) begin
                u_fpb = i_byte[5:0];
            end
            if (chain_hit) begin
                if (i_byte[7]) begin
                    u_pwo = r_pwo + OFF_W'(4);
                    if (ext_bad) begin
                        u_mal = 1'b1;
                    end
                end else begin
                    if (r_fpb[PB_TSFT]) begin
                        off = {off[OFF_W-1:3] + (OFF_W-3)'(off[2:0] != 3'd0), 3'd0}
                              + OFF_W'(8);
                    end
                    if (r_fpb[PB_FLAGS]) begin
                        off = off + OFF_W'(1);
                    end
                    if (r_fpb[PB_RATE]) begin
                        off = off + OFF_W'(1);
                    end
                    if (r_fpb[PB_CHANNEL]) begin
                        off    = off + OFF_W'(off[0]);
                        u_foff = off;
                        off    = off + OFF_W'(4);
                    end
                    if (r_fpb[PB_FHSS]) begin
                        off = off + OFF_W'(2);
                    end
                    if (r_fpb[PB_SIGNAL]) begin
                        u_soff = off;
                    end
                end
            end else begin
                if (r_chain == CHAIN_DONE) begin
                    if (r_fpb[PB_CHANNEL] && pos_x == r_foff) begin
                        u_freq[7:0] = i_byte;
                    end
                    if (r_fpb[PB_CHANNEL] && pos_x == r_foff + OFF_W'(1)) begin
                        u_freq[15:8] = i_byte;
                    end
                    if (r_fpb[PB_SIGNAL] && pos_x == r_soff) begin
                        u_sig = i_byte;
                    end
                end
                if (r_pos >= POS_PRESENT && hl_x >= MIN_HDR_LEN && pos_x >= hl_x) begin
                    if (rel == '0) begin
                        u_fc = i_byte;
                    end else if (rel >= OFF_W'(4) && rel < OFF_W'(10)) begin
                        u_a1 = {r_a1[MAC_W-9:0], i_byte};
                    end else if (rel >= OFF_W'(10) && rel < OFF_W'(16)) begin
                        u_a2 = {r_a2[MAC_W-9:0], i_byte};
                    end else if (rel >= OFF_W'(16) && rel < OFF_W'(22)) begin
                        u_a3 = {r_a3[MAC_W-9:0], i_byte};
                    end
                end
            end
        end

        // end of frame
        n_len = OFF_W'(u_pos);
        rem   = n_len - OFF_W'(u_hl);
        kind  = u_fc[3:2];
        sub   = u_fc[7:4];
        ok    = !(n_len < MIN_FRAME_LEN || u_mal || OFF_W'(u_hl) < MIN_HDR_LEN ||
                  OFF_W'(u_hl) > n_len || u_chain != CHAIN_DONE) && rem >= MIN_MAC_LEN;

        o_res                   = '0;
        o_res.frame_kind        = kind;
        o_res.frame_subkind     = sub;
        o_res.dest_address      = u_a1;
        if (kind == KIND_CONTROL) begin
            if ((sub == SUB_PS_POLL || sub == SUB_RTS) && rem >= CTRL_SRC_LEN) begin
                o_res.source_address    = u_a2;
                o_res.randomized_source = u_a2[RAND_BIT];
            end
        end else begin
            if (rem < FULL_MAC_LEN) begin
                ok = 1'b0;
            end
            o_res.source_address    = u_a2;
            o_res.bss_address       = u_a3;
            o_res.randomized_source = u_a2[RAND_BIT];
        end
        if (u_fpb[PB_CHANNEL] && r_foff + OFF_W'(4) <= OFF_W'(u_hl)) begin
            o_res.channel_number = i_chan;
        end
        if (u_fpb[PB_SIGNAL] && r_soff + OFF_W'(1) <= OFF_W'(u_hl)) begin
            o_res.signal_dbm = r_sig;
        end
        o_res_valid = i_last && ok;

        if (i_last) begin
            n_pos  = '0;
            n_hl   = '0;
            n_fpb  = '0;
            n_pwo  = FIRST_PRESENT;
            n_mal  = 1'b0;
            n_foff = '0;
            n_soff = '0;
            n_freq = '0;
            n_sig  = '0;
            n_fc   = '0;
            n_a1   = '0;
            n_a2   = '0;
            n_a3   = '0;
        end else begin
            n_pos  = u_pos;
            n_hl   = u_hl;
            n_fpb  = u_fpb;
            n_pwo  = u_pwo;
            n_mal  = u_mal;
            n_foff = u_foff;
            n_soff = u_soff;
            n_freq = u_freq;
            n_sig  = u_sig;
            n_fc   = u_fc;
            n_a1   = u_a1;
            n_a2   = u_a2;
            n_a3   = u_a3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hl    <= '0;
            r_fpb   <= '0;
            r_pwo   <= FIRST_PRESENT;
            r_chain <= CHAIN_FIRST;
            r_mal   <= 1'b0;
            r_foff  <= '0;
            r_soff  <= '0;
            r_freq  <= '0;
            r_sig   <= '0;
            r_fc    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_a3    <= '0;
        end else if (i_adv) begin
            r_pos   <= n_pos;
            r_hl    <= n_hl;
            r_fpb   <= n_fpb;
            r_pwo   <= n_pwo;
            r_chain <= n_chain;
            r_mal   <= n_mal;
            r_foff  <= n_foff;
            r_soff  <= n_soff;
            r_freq  <= n_freq;
            r_sig   <= n_sig;
            r_fc    <= n_fc;
            r_a1    <= n_a1;
            r_a2    <= n_a2;
            r_a3    <= n_a3;
        end
    end

    assign o_freq = r_freq;

endmodule

`default_nettype wire

@@ sv/rtp_checker.sv @@
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks of the header parser results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic [1:0]                o_frame_kind,
    input  wire logic [3:0]                o_frame_subkind,
    input  wire logic [rtp_pkg::MAC_W-1:0] o_source_address,
    input  wire logic [rtp_pkg::MAC_W-1:0] o_bss_address,
    input  wire logic                      o_randomized_source
);
    import rtp_pkg::*;

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // no result straight out of reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rand_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_randomized_source == o_source_address[RAND_BIT])
        else $error("randomized flag disagrees with source address");

    a_ctrl_bss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_kind == KIND_CONTROL |-> o_bss_address == '0)
        else $error("control frame with nonzero bss address");

    a_ctrl_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_kind == KIND_CONTROL &&
        o_frame_subkind != SUB_PS_POLL && o_frame_subkind != SUB_RTS
        |-> o_source_address == '0)
        else $error("control frame without address two has a source");

endmodule

bind radiotap_wifi_header_parser_unit rtp_checker u_rtp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_frame_kind        (o_frame_kind),
    .o_frame_subkind     (o_frame_subkind),
    .o_source_address    (o_source_address),
    .o_bss_address       (o_bss_address),
    .o_randomized_source (o_randomized_source)
);

`default_nettype wire

@@ tb/sv/radiotap_wifi_header_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// radiotap_wifi_header_parser_unit_tb
// Streams captured frames into the parser one byte per word and checks every
// frame summary against a cycle-free parse of the same bytes. A directed set
// covers header length limits, the present-word chain, field alignment and
// band edges; random frames follow, mostly well formed.
// ----------------------------------------------------------------------------
module radiotap_wifi_header_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtp_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 4;
    localparam int TOTAL_WORDS       = 1600;
    localparam int RANDOM_FRAMES_MIN = 12;
    localparam int TAIL_WORDS        = 200;
    localparam int DRAIN_CYCLES      = 20;
    localparam int STALL_LIMIT       = 2000;

    localparam int unsigned HDR_MIN      = 8;
    localparam int unsigned MAC_MIN      = 10;
    localparam int unsigned CTRL_SRC_MIN = 16;
    localparam int unsigned MAC_FULL     = 24;

    localparam logic [1:0] KIND_MGMT     = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [3:0] SUB_PLAIN     = 4'd0;
    localparam logic [3:0] SUB_BEACON    = 4'd8;
    localparam logic [3:0] SUB_ACK       = 4'd13;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_last_byte = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic signed [7:0] o_signal_dbm;
    logic [7:0]        o_channel_number;
    logic [1:0]        o_frame_kind;
    logic [3:0]        o_frame_subkind;
    logic [MAC_W-1:0]  o_dest_address;
    logic [MAC_W-1:0]  o_source_address;
    logic [MAC_W-1:0]  o_bss_address;
    logic              o_randomized_source;

    t_word       pending_bytes[$];
    t_result     frame_summaries[$];
    int          mismatches   = 0;
    bit          in_taken     = 1'b0;
    int          quiet_cycles = 0;
    int          send_gap     = 0;
    int          stall_gap    = 0;
    int          send_pct     = 0;
    int          stall_pct    = 0;
    int unsigned sent_words   = 0;
    int unsigned ready_cycles = 0;

    // frame parse state
    int unsigned      rx_count;
    int unsigned      rt_len;
    logic [5:0]       present_lo;
    int unsigned      chain_ptr;
    t_chain           chain_st;
    bit               bad_hdr;
    int unsigned      freq_at;
    int unsigned      sig_at;
    logic [15:0]      freq_val;
    logic [7:0]       sig_val;
    logic [7:0]       fc_byte;
    logic [MAC_W-1:0] addr1;
    logic [MAC_W-1:0] addr2;
    logic [MAC_W-1:0] addr3;

    radiotap_wifi_header_parser_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_signal_dbm        (o_signal_dbm),
        .o_channel_number    (o_channel_number),
        .o_frame_kind        (o_frame_kind),
        .o_frame_subkind     (o_frame_subkind),
        .o_dest_address      (o_dest_address),
        .o_source_address    (o_source_address),
        .o_bss_address       (o_bss_address),
        .o_randomized_source (o_randomized_source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // aligned offsets of channel and signal after the last present word
    function automatic void lay_out(input logic [5:0] pb, input int unsigned base,
                                    output int unsigned fa, output int unsigned sa,
                                    output int unsigned fend);
        int unsigned off;
        off = base;
        fa  = 0;
        if (pb[PB_TSFT]) off = ((off + 7) & ~32'd7) + 8;
        if (pb[PB_FLAGS]) off = off + 1;
        if (pb[PB_RATE]) off = off + 1;
        if (pb[PB_CHANNEL]) begin
            off = (off + 1) & ~32'd1;
            fa  = off;
            off = off + 4;
        end
        if (pb[PB_FHSS]) off = off + 2;
        sa = off;
        if (pb[PB_SIGNAL]) off = off + 1;
        fend = off;
    endfunction

    function automatic int unsigned fit_len(input int unsigned n_ext, input logic [5:0] pb);
        int unsigned fa;
        int unsigned sa;
        int unsigned fend;
        lay_out(pb, 8 + 4 * n_ext, fa, sa, fend);
        return fend;
    endfunction

    function automatic logic [7:0] band_channel(input logic [15:0] f);
        int unsigned v;
        v = {16'd0, f};
        if (v == 2484) return 8'd14;
        if (v >= 2412 && v <= 2472) return 8'((v - 2412) / 5 + 1);
        if (v >= 5160 && v <= 5885) return 8'((v - 5000) / 5);
        if (v >= 5955 && v <= 7115) return 8'((v - 5950) / 5);
        return 8'd0;
    endfunction

    task automatic clear_frame_state();
        rx_count   = 0;
        rt_len     = 0;
        present_lo = '0;
        chain_ptr  = 4;
        chain_st   = CHAIN_FIRST;
        bad_hdr    = 1'b0;
        freq_at    = 0;
        sig_at     = 0;
        freq_val   = '0;
        sig_val    = '0;
        fc_byte    = '0;
        addr1      = '0;
        addr2      = '0;
        addr3      = '0;
    endtask

    task automatic absorb_byte(input int unsigned pos, input logic [7:0] b);
        int unsigned rel;
        int unsigned fend;
        if (pos == 2) rt_len = {24'd0, b};
        if (pos == 3) begin
            rt_len = rt_len | (int'(b) << 8);
            if (rt_len < HDR_MIN) bad_hdr = 1'b1;
        end
        if (bad_hdr) return;
        if (pos == 4) present_lo = b[5:0];
        // top byte of a present word: bit 31 extends the chain
        if (chain_st != CHAIN_DONE && pos >= 4 && pos == chain_ptr + 3) begin
            if (b[7]) begin
                chain_ptr = chain_ptr + 4;
                if (chain_ptr + 4 > rt_len) bad_hdr = 1'b1;
                else chain_st = CHAIN_EXT;
            end else begin
                lay_out(present_lo, chain_ptr + 4, freq_at, sig_at, fend);
                chain_st = CHAIN_DONE;
            end
            return;
        end
        if (chain_st == CHAIN_DONE) begin
            if (present_lo[PB_CHANNEL]) begin
                if (pos == freq_at) freq_val[7:0] = b;
                if (pos == freq_at + 1) freq_val[15:8] = b;
            end
            if (present_lo[PB_SIGNAL] && pos == sig_at) sig_val = b;
        end
        if (pos >= 4 && rt_len >= HDR_MIN && pos >= rt_len) begin
            rel = pos - rt_len;
            if (rel == 0) fc_byte = b;
            else if (rel >= 4 && rel < 10) addr1 = {addr1[MAC_W-9:0], b};
            else if (rel >= 10 && rel < 16) addr2 = {addr2[MAC_W-9:0], b};
            else if (rel >= 16 && rel < 22) addr3 = {addr3[MAC_W-9:0], b};
        end
    endtask

    task automatic close_frame();
        int unsigned remaining;
        t_result     r;
        if (rx_count < HDR_MIN || bad_hdr || rt_len < HDR_MIN || rt_len > rx_count ||
            chain_st != CHAIN_DONE) return;
        remaining = rx_count - rt_len;
        if (remaining < MAC_MIN) return;
        r = '0;
        r.frame_kind    = fc_byte[3:2];
        r.frame_subkind = fc_byte[7:4];
        r.dest_address  = addr1;
        if (r.frame_kind == KIND_CONTROL) begin
            if ((r.frame_subkind == SUB_PS_POLL || r.frame_subkind == SUB_RTS) &&
                remaining >= CTRL_SRC_MIN) r.source_address = addr2;
        end else begin
            if (remaining < MAC_FULL) return;
            r.source_address = addr2;
            r.bss_address    = addr3;
        end
        r.randomized_source = r.source_address[RAND_BIT];
        if (present_lo[PB_CHANNEL] && freq_at + 4 <= rt_len)
            r.channel_number = band_channel(freq_val);
        if (present_lo[PB_SIGNAL] && sig_at + 1 <= rt_len)
            r.signal_dbm = sig_val;
        frame_summaries.push_back(r);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        // a capture buffer of MAX_FRAME_BYTES truncates longer frames
        if (rx_count < MAX_FRAME_BYTES) begin
            absorb_byte(rx_count, b);
            rx_count = rx_count + 1;
        end
        if (last) begin
            close_frame();
            clear_frame_state();
        end
    endtask

    // random bytes, then length, present words, fields and frame control on top
    task automatic add_frame(input int unsigned hl, input int unsigned n_ext,
                             input logic [5:0] pbits, input logic [15:0] freq,
                             input logic [7:0] sig, input logic [7:0] fc,
                             input int unsigned total);
        logic [7:0]  fb[];
        int unsigned fa;
        int unsigned sa;
        int unsigned fend;
        int unsigned w;
        t_word       item;
        fb = new[total];
        foreach (fb[i]) fb[i] = 8'($urandom);
        if (total > 2) fb[2] = hl[7:0];
        if (total > 3) fb[3] = hl[15:8];
        for (int k = 0; k <= n_ext; k++) begin
            w = 4 + 4 * k;
            if (k == 0 && w < total) fb[w][5:0] = pbits;
            if (w + 3 < total) fb[w+3][7] = (k < n_ext);
        end
        lay_out(pbits, 8 + 4 * n_ext, fa, sa, fend);
        if (pbits[PB_CHANNEL] && fa < total) fb[fa] = freq[7:0];
        if (pbits[PB_CHANNEL] && fa + 1 < total) fb[fa+1] = freq[15:8];
        if (pbits[PB_SIGNAL] && sa < total) fb[sa] = sig;
        if (hl < total) fb[hl] = fc;
        foreach (fb[i]) begin
            item.data = fb[i];
            item.last = (i == total - 1);
            pending_bytes.push_back(item);
        end
    endtask

    function automatic logic [7:0] make_fc(input logic [1:0] kind, input logic [3:0] sub);
        return {sub, kind, 2'b00};
    endfunction

    function automatic logic [15:0] pick_freq();
        logic [15:0] band_edges[8] = '{16'd2411, 16'd2473, 16'd2483, 16'd2485,
                                       16'd5159, 16'd5886, 16'd5954, 16'd7116};
        case ($urandom_range(5, 0))
            0: return 16'(2412 + $urandom_range(60, 0));
            1: return 16'd2484;
            2: return 16'(5160 + $urandom_range(725, 0));
            3: return 16'(5955 + $urandom_range(1160, 0));
            4: return band_edges[$urandom_range(7, 0)];
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 3;
            2: return 10;
            default: return 30;
        endcase
    endfunction

    task automatic directed_frames();
        logic [15:0] band_freqs[8] = '{16'd2412, 16'd2472, 16'd2484, 16'd5160,
                                       16'd5885, 16'd5955, 16'd7115, 16'd7116};
        logic [7:0]  sig_ends[2]   = '{8'h80, 8'h7F};
        int unsigned hl;
        logic [5:0]  pb;
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 32);
        // short capture, bad header lengths, chain running past the header
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 7);
        add_frame(7, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 40);
        add_frame(65535, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 40);
        add_frame(8, 1, 6'h3F, 16'd2437, 8'hC4, make_fc(KIND_DATA, SUB_PLAIN), 40);
        // band edges, every present bit, chained words
        foreach (band_freqs[i]) begin
            pb = (i % 2 == 0) ? 6'h3F : 6'h28;
            hl = fit_len(i % 3, pb);
            add_frame(hl, i % 3, pb, band_freqs[i], sig_ends[i % 2],
                      make_fc(KIND_MGMT, SUB_BEACON), hl + 24);
        end
        // channel and signal past, partly past or just inside the header
        add_frame(8, 0, 6'h08, 16'd2437, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 32);
        add_frame(11, 0, 6'h08, 16'd2437, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 35);
        add_frame(8, 0, 6'h20, 16'd0, 8'hC4, make_fc(KIND_DATA, SUB_PLAIN), 32);
        add_frame(9, 0, 6'h20, 16'd0, 8'hC4, make_fc(KIND_DATA, SUB_PLAIN), 33);
        // MAC header lengths around each limit
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 17);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_CONTROL, SUB_ACK), 18);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_CONTROL, SUB_RTS), 23);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_CONTROL, SUB_RTS), 24);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_CONTROL, SUB_PS_POLL), 24);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 31);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_RESERVED, SUB_PLAIN), 32);
        add_frame(8, 0, 6'h00, 16'd0, 8'h00, make_fc(KIND_DATA, SUB_PLAIN), 32);
    endtask

    task automatic random_frame();
        int unsigned n_ext;
        int unsigned hl;
        int unsigned fit;
        int unsigned mac;
        int unsigned total;
        logic [5:0]  pb;
        logic [1:0]  kind;
        logic [3:0]  sub;
        n_ext = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        pb    = 6'($urandom);
        fit   = fit_len(n_ext, pb);
        if ($urandom_range(9, 0) == 0) hl = $urandom_range(fit, 8);
        else hl = fit + $urandom_range(6, 0);
        kind = 2'($urandom);
        sub  = 4'($urandom);
        if (kind == KIND_CONTROL && $urandom_range(1, 0) == 1)
            sub = 4'($urandom_range(SUB_RTS, SUB_PS_POLL));
        if (kind == KIND_CONTROL) mac = $urandom_range(20, 8);
        else if ($urandom_range(7, 0) == 0) mac = $urandom_range(23, 8);
        else mac = $urandom_range(34, 24);
        total = hl + mac;
        // broken capture: random length and header length
        if ($urandom_range(7, 0) == 0) begin
            total = $urandom_range(48, 1);
            hl = ($urandom_range(1, 0) == 1) ? $urandom_range(65535, 0)
                                             : $urandom_range(total, 0);
        end
        add_frame(hl, n_ext, pb, pick_freq(), 8'($urandom), {sub, kind, 2'($urandom)},
                  total);
    endtask

    task automatic check_field(input string what, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // handshakes, prediction, checking and watchdog at the rising edge
    always @(posedge i_clk) begin : sample
        t_result want;
        bit      out_fire;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (in_taken) parse_byte(i_data_byte, i_last_byte);
        if (out_fire) begin
            if (frame_summaries.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual dest %h kind %0d",
                         $time, o_dest_address, o_frame_kind);
                mismatches++;
            end else begin
                want = frame_summaries.pop_front();
                check_field("signal_dbm", 48'($unsigned(want.signal_dbm)),
                            48'($unsigned(o_signal_dbm)));
                check_field("channel_number", 48'(want.channel_number),
                            48'(o_channel_number));
                check_field("frame_kind", 48'(want.frame_kind), 48'(o_frame_kind));
                check_field("frame_subkind", 48'(want.frame_subkind),
                            48'(o_frame_subkind));
                check_field("dest_address", want.dest_address, o_dest_address);
                check_field("source_address", want.source_address, o_source_address);
                check_field("bss_address", want.bss_address, o_bss_address);
                check_field("randomized_source", 48'(want.randomized_source),
                            48'(o_randomized_source));
            end
        end
        if (in_taken || out_fire || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("radiotap_wifi_header_parser_unit_tb: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin : drive_bytes
        t_word w;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() > TAIL_WORDS &&
                         $urandom_range(99, 0) < send_pct) begin
                send_gap = $urandom_range(16, 1) - 1;
                i_in_valid <= 1'b0;
            end else begin
                w = pending_bytes.pop_front();
                i_data_byte <= w.data;
                i_last_byte <= w.last;
                i_in_valid  <= 1'b1;
                sent_words++;
                if (sent_words % 100 == 0) send_pct = pick_idle_pct();
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            ready_cycles++;
            if (ready_cycles % 100 == 0) stall_pct = pick_idle_pct();
            if (stall_gap > 0) begin
                stall_gap--;
                i_out_ready <= 1'b0;
            end else if (pending_bytes.size() > TAIL_WORDS &&
                         $urandom_range(99, 0) < stall_pct) begin
                stall_gap = $urandom_range(16, 1) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : main
        int n_frames;
        clear_frame_state();
        directed_frames();
        n_frames = 0;
        // random frames top the stream up to the planned word count and the minimum frame count
        while (pending_bytes.size() < TOTAL_WORDS || n_frames < RANDOM_FRAMES_MIN) begin
            random_frame();
            n_frames++;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (frame_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("radiotap_wifi_header_parser_unit_tb: PASS");
        end else begin
            $display("radiotap_wifi_header_parser_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/rtp_pkg.sv
sv/rtp_chan.sv
sv/rtp_parse.sv
sv/radiotap_wifi_header_parser_unit.sv
sv/rtp_checker.sv
tb/sv/radiotap_wifi_header_parser_unit_tb.sv
